[rtl/sitda_pkg.sv]
// Package for the signed integer to decimal text converter.
// Holds widths, character codes, state types and the digit adjust function.
// Depends on nothing; every other file imports it.
`default_nettype none

package sitda_pkg;

	// Field and datapath widths.
	localparam int VALUE_W  = 32;
	localparam int CHAR_W   = 8;
	localparam int DIGITS   = 10;
	localparam int DIGIT_W  = 4;
	localparam int BCD_W    = DIGITS * DIGIT_W;
	localparam int BITCNT_W = $clog2(VALUE_W);
	localparam int DIGCNT_W = $clog2(DIGITS + 1);

	// Character codes.
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [3:0]        ZERO_HI    = 4'h3;

	// Converter states.
	typedef enum logic [1:0] {
		CNV_IDLE,
		CNV_RUN,
		CNV_HOLD
	} cnv_state_t;

	// Emitter states.
	typedef enum logic [1:0] {
		EMIT_IDLE,
		EMIT_SIGN,
		EMIT_SKIP,
		EMIT_DIGIT
	} emit_state_t;

	// Result handed from the converter to the emitter.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic             negative;
	} cnv_result_t;

	// Double dabble correction: a digit of five or more gets three added
	// before the shift, so that it carries correctly into the next digit.
	function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] r;
		r = (d >= 4'd5) ? d + 4'd3 : d;
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/sitda_value_if.sv]
// Channel interface carrying one signed integer per beat.
// Depends on sitda_pkg for the field width.
`default_nettype none

interface sitda_value_if
	import sitda_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

[rtl/sitda_char_if.sv]
// Channel interface carrying one ASCII character and its last flag per beat.
// Depends on sitda_pkg for the field width.
`default_nettype none

interface sitda_char_if
	import sitda_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

[rtl/sitda_bin2bcd.sv]
// Bit-serial binary to BCD converter using the shift and add-three method.
// Depends on sitda_pkg and sitda_value_if.
`default_nettype none

module sitda_bin2bcd
	import sitda_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	sitda_value_if.sink         num,
	output cnv_result_t         res,
	output logic                res_valid,
	input  wire logic           res_take
);

	cnv_state_t          state_q, state_d;
	logic [BITCNT_W-1:0] cnt_q;
	logic [VALUE_W-1:0]  mag_q;
	logic [BCD_W-1:0]    bcd_q;
	logic                neg_q;
	logic [BCD_W-1:0]    bcd_adj;
	logic                accept;

	assign accept = num.valid && num.ready;

	// Correct every digit, then the shift below brings in the next bit.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_adjust(bcd_q[i*DIGIT_W +: DIGIT_W]);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			CNV_IDLE: begin
				if (accept) state_d = CNV_RUN;
			end
			CNV_RUN: begin
				if (cnt_q == BITCNT_W'(VALUE_W - 1)) state_d = CNV_HOLD;
			end
			CNV_HOLD: begin
				if (res_take) state_d = CNV_IDLE;
			end
			default: state_d = CNV_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		num.ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			CNV_IDLE: num.ready = 1'b1;
			CNV_HOLD: res_valid = 1'b1;
			default: begin
				num.ready = 1'b0;
				res_valid = 1'b0;
			end
		endcase
	end

	assign res.bcd      = bcd_q;
	assign res.negative = neg_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CNV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= '0;
			else if (state_q == CNV_RUN) cnt_q <= cnt_q + 1'b1;
		end
	end

	// Magnitude is taken on the accepted beat, then shifted out MSB first.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= num.value[VALUE_W-1];
			mag_q <= num.value[VALUE_W-1] ? VALUE_W'(0 - num.value) : num.value;
			bcd_q <= '0;
		end else if (state_q == CNV_RUN) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
		end
	end

endmodule

`default_nettype wire

[rtl/sitda_emit.sv]
// Character emitter: sends the sign if negative, drops leading zeros, then sends one
// digit per beat, most significant first. Depends on sitda_pkg, sitda_char_if.
`default_nettype none

module sitda_emit
	import sitda_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cnv_result_t res,
	input  wire logic        res_valid,
	output logic             res_take,
	sitda_char_if.source     text
);

	emit_state_t         state_q, state_d;
	logic [BCD_W-1:0]    dig_q;
	logic [DIGCNT_W-1:0] cnt_q;
	logic [DIGIT_W-1:0]  top;
	logic                skip;
	logic                final_digit;

	assign top         = dig_q[BCD_W-1 -: DIGIT_W];
	assign final_digit = (cnt_q == DIGCNT_W'(1));
	assign skip        = (top == '0) && !final_digit;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			EMIT_IDLE: begin
				if (res_valid) state_d = res.negative ? EMIT_SIGN : EMIT_SKIP;
			end
			EMIT_SIGN: begin
				if (text.ready) state_d = EMIT_SKIP;
			end
			EMIT_SKIP: begin
				if (!skip) state_d = EMIT_DIGIT;
			end
			EMIT_DIGIT: begin
				if (text.ready && final_digit) state_d = EMIT_IDLE;
			end
			default: state_d = EMIT_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		res_take       = 1'b0;
		text.valid     = 1'b0;
		text.character = {ZERO_HI, top};
		text.last      = 1'b0;
		case (state_q)
			EMIT_IDLE: res_take = res_valid;
			EMIT_SIGN: begin
				text.valid     = 1'b1;
				text.character = CHAR_MINUS;
			end
			EMIT_DIGIT: begin
				text.valid = 1'b1;
				text.last  = final_digit;
			end
			default: text.valid = 1'b0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EMIT_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == EMIT_IDLE && res_valid) begin
				cnt_q <= DIGCNT_W'(DIGITS);
			end else if ((state_q == EMIT_SKIP && skip) ||
			             (state_q == EMIT_DIGIT && text.ready)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Digit shift register moves one digit up per skipped or sent digit.
	always_ff @(posedge clk) begin
		if (state_q == EMIT_IDLE && res_valid) begin
			dig_q <= res.bcd;
		end else if ((state_q == EMIT_SKIP && skip) ||
		             (state_q == EMIT_DIGIT && text.ready)) begin
			dig_q <= {dig_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

endmodule

`default_nettype wire

[rtl/signed_int_to_decimal_ascii_top.sv]
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_value_if, sitda_char_if, sitda_bin2bcd, sitda_emit.
//
//   Port  Dir   Payload                      Beat
//   num   sink  value  (signed 32 bits)      one integer
//   text  src   character (8 bits), last     one character of the text
//
// The converter takes one input bit per cycle while it runs, and takes a new
// value only once the emitter has taken the previous result.
// The emitter works on the previous value meanwhile, dropping leading
// zeros and sending one beat per character, at most eleven characters.
// arst_n clears both state machines; a stalled text channel holds the
// emitter, and the converter then waits in its hold state with the result.
`default_nettype none

module signed_int_to_decimal_ascii_top
	import sitda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	sitda_value_if.sink  num,
	sitda_char_if.source text
);

	cnv_result_t res;
	logic        res_valid;
	logic        res_take;

	// Binary to BCD, one bit per cycle.
	sitda_bin2bcd u_bin2bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take)
	);

	// Sign and digits out, one per beat.
	sitda_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take),
		.text      (text)
	);

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for signed_int_to_decimal_ascii_top.
// Needs sitda_pkg, both channel interfaces and the RTL. A scoreboard class
// predicts the decimal text of every accepted integer and checks each character.
`default_nettype none

module testbench;
	import sitda_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 3000;
	localparam int PHASE_ITEMS = 97;
	localparam int DRAIN_WAIT  = 60;

	// One expected character beat on the text channel.
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_beat_t;

	// Receiver behaviour, chosen per phase.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_MASK,
		RX_SPARSE
	} rx_mode_t;

	// Scoreboard: turns each accepted integer into its expected characters
	// and compares them, in order, with the beats leaving the block.
	class decimal_text_board;
		text_beat_t expected_chars[$];
		int         errors;
		int         values_seen;
		int         negatives_seen;
		int         chars_checked;
		int         longest_text;

		function new();
			errors         = 0;
			values_seen    = 0;
			negatives_seen = 0;
			chars_checked  = 0;
			longest_text   = 0;
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 20) begin
				$display("mismatch: %s", msg);
			end
		endtask

		// Magnitude in unsigned arithmetic, so the most negative value works.
		function void note_value(input logic signed [VALUE_W-1:0] v);
			logic [VALUE_W-1:0] mag;
			logic [DIGIT_W-1:0] digs [DIGITS];
			int                 n;
			int                 len;
			text_beat_t         beat;
			mag = $unsigned(v);
			if (v[VALUE_W-1]) begin
				mag = ~mag + 1'b1;
			end
			n = 0;
			do begin
				digs[n] = DIGIT_W'(mag % 10);
				mag     = mag / 10;
				n++;
			end while (mag != 0 && n < DIGITS);
			len = n;
			if (v[VALUE_W-1]) begin
				beat.character = CHAR_MINUS;
				beat.last      = 1'b0;
				expected_chars.push_back(beat);
				negatives_seen++;
				len++;
			end
			for (int k = n - 1; k >= 0; k--) begin
				beat.character = {ZERO_HI, digs[k]};
				beat.last      = (k == 0);
				expected_chars.push_back(beat);
			end
			values_seen++;
			if (len > longest_text) begin
				longest_text = len;
			end
		endfunction

		task check_char(input logic [CHAR_W-1:0] character, input logic last);
			text_beat_t want;
			if (expected_chars.size() == 0) begin
				report($sformatf("character %h last %b with nothing expected",
					character, last));
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (character !== want.character) begin
					report($sformatf("character %h, expected %h (beat %0d)",
						character, want.character, chars_checked));
				end
				if (last !== want.last) begin
					report($sformatf("last %b, expected %b on character %h (beat %0d)",
						last, want.last, want.character, chars_checked));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	sitda_value_if num ();
	sitda_char_if  text ();

	signed_int_to_decimal_ascii_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.text   (text)
	);

	decimal_text_board sb = new();

	rx_mode_t    rx_mode;
	logic [15:0] rx_mask;
	logic        hold_request;
	int          hold_left;
	logic        tx_bursty;
	int          burst_left;

	logic signed [VALUE_W-1:0] directed_values [22] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
		32'sd100, 32'sd12345, -32'sd67890, 32'sd999999999, 32'sd1000000000,
		-32'sd1000000000, 32'sh7FFFFFFF, -32'sd2147483647, 32'sh80000000,
		32'sh55555555, 32'shAAAAAAAA, 32'sd1234567890, -32'sd1073741824,
		32'sd1000000001
	};

	// Clock: period of 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: a long hold-off when asked for, otherwise the phase's pattern.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			text.ready = 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: begin
					text.ready = 1'b1;
				end
				RX_MOSTLY: begin
					text.ready = ($urandom_range(0, 3) != 0);
				end
				RX_MASK: begin
					rx_mask    = {rx_mask[14:0], rx_mask[15]};
					text.ready = rx_mask[0];
				end
				default: begin
					text.ready = ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// Every character accepted on the text channel goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && text.valid && text.ready) begin
			sb.check_char(text.character, text.last);
		end
	end

	// Watchdog: ends the run once nothing has moved for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((num.valid && num.ready) || (text.valid && text.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("watchdog: no beat for %0d cycles, %0d characters outstanding",
			IDLE_LIMIT, sb.pending());
		$display("testbench: FAIL");
		$finish;
	end

	function automatic longint ten_pow(input int k);
		longint p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// Random integers: raw bit patterns, small values, values of a chosen
	// digit count, and values around powers of ten and the extremes.
	function automatic logic signed [VALUE_W-1:0] random_value();
		longint lo;
		longint hi;
		longint m;
		int     k;
		case ($urandom_range(0, 3))
			0: begin
				m = $urandom;
			end
			1: begin
				m = longint'($urandom_range(0, 2000)) - 1000;
			end
			2: begin
				k  = $urandom_range(1, 10);
				lo = (k == 1) ? 0 : ten_pow(k - 1);
				hi = (k == 10) ? 64'd2147483647 : ten_pow(k) - 1;
				m  = lo + $urandom_range(0, 32'(hi - lo));
				if ($urandom_range(0, 1)) m = -m;
			end
			default: begin
				if ($urandom_range(0, 7) == 0) begin
					m = $urandom_range(0, 1) ? 64'd2147483647 : -64'd2147483648;
				end else begin
					m = ten_pow($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
					if ($urandom_range(0, 1)) m = -m;
				end
			end
		endcase
		return m[VALUE_W-1:0];
	endfunction

	// Offers one integer from a falling edge and waits for its beat; in
	// bursty mode a random gap follows the end of each burst.
	task automatic send_value(input logic signed [VALUE_W-1:0] v);
		num.valid = 1'b1;
		num.value = v;
		do @(posedge clk); while (!num.ready);
		sb.note_value(v);
		@(negedge clk);
		if (tx_bursty) begin
			if (burst_left == 0) begin
				num.valid = 1'b0;
				num.value = $urandom;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				burst_left = $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Lowers valid and holds the sender until every character has arrived.
	task automatic drain_text();
		num.valid = 1'b0;
		while (sb.pending() > 0) @(negedge clk);
	endtask

	task automatic start_phase(input rx_mode_t mode, input logic bursty);
		rx_mode    = mode;
		rx_mask    = 16'($urandom) | 16'h0001;
		tx_bursty  = bursty;
		burst_left = $urandom_range(1, 6);
	endtask

	// Stimulus: directed corner values, then four random phases with
	// different sender and receiver behaviour.
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		num.valid    = 1'b0;
		num.value    = '0;
		text.ready   = 1'b0;
		hold_request = 1'b0;
		hold_left    = 0;
		start_phase(RX_ALWAYS, 1'b0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_values[i]) begin
			send_value(directed_values[i]);
		end
		drain_text();

		start_phase(RX_ALWAYS, 1'b0);
		repeat (PHASE_ITEMS) send_value(random_value());

		start_phase(RX_MOSTLY, 1'b1);
		repeat (PHASE_ITEMS) send_value(random_value());
		// The sender stops here until the text channel has caught up.
		drain_text();

		// The receiver holds off while the sender keeps offering, so the
		// block fills up and stalls its input.
		start_phase(RX_MASK, 1'b1);
		hold_request = 1'b1;
		repeat (PHASE_ITEMS) send_value(random_value());

		start_phase(RX_SPARSE, 1'b0);
		repeat (PHASE_ITEMS) send_value(random_value());
		drain_text();

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d integers (%0d negative), %0d characters checked",
			sb.values_seen, sb.negatives_seen, sb.chars_checked);
		$display("longest text %0d characters; receiver held off %0d cycles once",
			sb.longest_text, HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
